>>> src/kwre_pkg.sv
`timescale 1ns / 1ps
// kwre_pkg: shared types, register indexes and fixed-point constants of the ratio estimator.
// Also builds the 2^f interpolation table entries. No dependencies.
package kwre_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_EVAL_TIME       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EVAL_LANDMARK   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_BW_TIME     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_BW_LANDMARK = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_GROUP    = 3'd4;

  localparam logic [30:0] LOG2E_Q30   = 31'd1549082005;
  localparam logic [34:0] THREE_Q30   = 35'h0_C000_0000;
  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
  localparam logic [63:0] SUM_POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SUM_NEG_MAX = 64'h8000_0000_0000_0001;

  typedef struct packed {
    logic signed [31:0] eval_time;
    logic signed [31:0] eval_landmark;
    logic [31:0]        inv_bw_time;
    logic [31:0]        inv_bw_landmark;
    logic [1:0]         target_group;
  } cfg_t;

  typedef struct packed {
    logic [31:0]        dist_time;
    logic [31:0]        dist_landmark;
    logic signed [31:0] response;
    logic signed [19:0] score;
    logic               hit;
    logic               last;
  } item_t;

  typedef struct packed {
    logic [63:0] num;
    logic [63:0] den;
    logic        ovf;
  } batch_t;

  typedef struct packed {
    logic signed [31:0] estimate;
    logic               empty_window;
    logic               saturated;
  } result_t;

  function automatic logic [63:0] isqrt64(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] xx;
    r  = '0;
    b  = 64'h4000_0000_0000_0000;
    xx = x;
    for (int k = 0; k < 32; k++) begin
      if (b > xx) b = b >> 2;
    end
    for (int k = 0; k < 32; k++) begin
      if (b != 64'd0) begin
        if (xx >= r + b) begin
          xx = xx - (r + b);
          r  = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] exp_entry(int unsigned i, int unsigned tb);
    logic [63:0] r;
    logic [63:0] e;
    r = 64'd2 << 30;
    for (int unsigned k = 0; k < 8; k++) begin
      if (k < tb) r = isqrt64(r << 30);
    end
    e = 64'd1 << 30;
    for (int unsigned k = 1; k < 256; k++) begin
      if (k <= i) e = (e * r + (64'd1 << 29)) >> 30;
    end
    if (i == (32'd1 << tb)) e = 64'd2 << 30;
    return e[31:0];
  endfunction

endpackage

>>> src/kernel_weighted_ratio_estimate.sv
`timescale 1ns / 1ps
// kernel_weighted_ratio_estimate: top level; configuration registers, front queue, back
// sequencer, divider and result register. Depends on kwre_pkg and the kwre_* modules.
// A contributing subject runs its full step sequence on the shared multiplier; one of another
// group skips it, and one outside the time or landmark window leaves it at that window's check.
// The last subject adds a bit-serial division, cut short when the denominator is zero or
// the ratio clamps. Each subject is finished before the next is taken from the queue.
// Two subjects queue ahead. Reset is asynchronous, active low: sums and queues clear,
// registers take their defaults.
module kernel_weighted_ratio_estimate #(
  parameter int unsigned EXP_TABLE_BITS = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] subject_time_i,
  input  logic signed [31:0] subject_landmark_i,
  input  logic signed [31:0] response_i,
  input  logic [1:0]         group_i,
  input  logic signed [19:0] linear_score_i,
  input  logic               last_subject_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] estimate_o,
  output logic               empty_window_o,
  output logic               saturated_o
);
  import kwre_pkg::*;

  cfg_t    cfg_q;
  item_t   item;
  logic    item_valid, item_take;
  batch_t  batch;
  logic    batch_valid, batch_ready;
  result_t res, out_q;
  logic    res_valid, res_ready;
  logic    out_valid_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.eval_time       <= '0;
      cfg_q.eval_landmark   <= '0;
      cfg_q.inv_bw_time     <= 32'd65536;
      cfg_q.inv_bw_landmark <= 32'd65536;
      cfg_q.target_group    <= 2'd1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_EVAL_TIME:       cfg_q.eval_time       <= cfg_data_i;
        CFG_EVAL_LANDMARK:   cfg_q.eval_landmark   <= cfg_data_i;
        CFG_INV_BW_TIME:     cfg_q.inv_bw_time     <= cfg_data_i;
        CFG_INV_BW_LANDMARK: cfg_q.inv_bw_landmark <= cfg_data_i;
        CFG_TARGET_GROUP:    cfg_q.target_group    <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  kwre_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .push               (push),
    .full               (full),
    .subject_time_i     (subject_time_i),
    .subject_landmark_i (subject_landmark_i),
    .response_i         (response_i),
    .group_i            (group_i),
    .linear_score_i     (linear_score_i),
    .last_subject_i     (last_subject_i),
    .item_valid_o       (item_valid),
    .item_o             (item),
    .item_take_i        (item_take)
  );

  kwre_back #(
    .EXP_TABLE_BITS (EXP_TABLE_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .item_valid_i  (item_valid),
    .item_i        (item),
    .item_take_o   (item_take),
    .batch_valid_o (batch_valid),
    .batch_o       (batch),
    .batch_ready_i (batch_ready)
  );

  kwre_div u_div (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .batch_valid_i (batch_valid),
    .batch_i       (batch),
    .batch_ready_o (batch_ready),
    .res_valid_o   (res_valid),
    .res_o         (res),
    .res_ready_i   (res_ready)
  );

  assign res_ready = !out_valid_q || pop;

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) out_q <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  assign empty          = !out_valid_q;
  assign estimate_o     = out_q.estimate;
  assign empty_window_o = out_q.empty_window;
  assign saturated_o    = out_q.saturated;

`ifndef ASSERT_OFF
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && empty_window_o) |-> (estimate_o == 32'sd0))
    else $error("empty window result carries a nonzero estimate");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (batch_valid && batch_ready) |=> !batch_ready)
    else $error("divider took a batch but stayed ready");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res_ready) |=> !empty)
    else $error("result handed over but output register empty");
`endif

endmodule

>>> src/kwre_front.sv
`timescale 1ns / 1ps
// kwre_front: accepts subjects, forms window distances and the group match, and queues them.
// Depends on kwre_pkg.
module kwre_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kwre_pkg::cfg_t     cfg_i,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] subject_time_i,
  input  logic signed [31:0] subject_landmark_i,
  input  logic signed [31:0] response_i,
  input  logic [1:0]         group_i,
  input  logic signed [19:0] linear_score_i,
  input  logic               last_subject_i,
  output logic               item_valid_o,
  output kwre_pkg::item_t    item_o,
  input  logic               item_take_i
);
  import kwre_pkg::*;

  function automatic logic [31:0] abs_diff(logic [31:0] a, logic [31:0] b);
    logic [32:0] d;
    logic [32:0] nd;
    d  = {a[31], a} - {b[31], b};
    nd = 33'd0 - d;
    return d[32] ? nd[31:0] : d[31:0];
  endfunction

  item_t       fifo_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q;
  logic        wr_en, rd_en;
  item_t       new_item;

  assign full         = (count_q == 2'd2);
  assign item_valid_o = (count_q != 2'd0);
  assign item_o       = fifo_q[rd_ptr_q];
  assign wr_en        = push && !full;
  assign rd_en        = item_take_i && item_valid_o;

  always_comb begin
    new_item.dist_time     = abs_diff(cfg_i.eval_time, subject_time_i);
    new_item.dist_landmark = abs_diff(cfg_i.eval_landmark, subject_landmark_i);
    new_item.response      = response_i;
    new_item.score         = linear_score_i;
    new_item.hit           = (group_i == cfg_i.target_group);
    new_item.last          = last_subject_i;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) fifo_q[wr_ptr_q] <= new_item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (wr_en) wr_ptr_q <= ~wr_ptr_q;
      if (rd_en) rd_ptr_q <= ~rd_ptr_q;
      if (wr_en && !rd_en) count_q <= count_q + 2'd1;
      else if (rd_en && !wr_en) count_q <= count_q - 2'd1;
    end
  end

endmodule

>>> src/kwre_back.sv
`timescale 1ns / 1ps
// kwre_back: per-subject kernel weight, exp and accumulation on one shared multiplier.
// Depends on kwre_pkg.
module kwre_back #(
  parameter int unsigned EXP_TABLE_BITS = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  kwre_pkg::cfg_t   cfg_i,
  input  logic             item_valid_i,
  input  kwre_pkg::item_t  item_i,
  output logic             item_take_o,
  output logic             batch_valid_o,
  output kwre_pkg::batch_t batch_o,
  input  logic             batch_ready_i
);
  import kwre_pkg::*;

  localparam int unsigned TAB_N = 1 << EXP_TABLE_BITS;
  localparam int unsigned IW    = EXP_TABLE_BITS + 1;

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_U_MUL  = 5'd1;
  localparam logic [4:0] ST_U_CHK  = 5'd2;
  localparam logic [4:0] ST_V_MUL  = 5'd3;
  localparam logic [4:0] ST_V_SET  = 5'd4;
  localparam logic [4:0] ST_O2_MUL = 5'd5;
  localparam logic [4:0] ST_O2_SET = 5'd6;
  localparam logic [4:0] ST_O3_MUL = 5'd7;
  localparam logic [4:0] ST_O3_SET = 5'd8;
  localparam logic [4:0] ST_K_MUL  = 5'd9;
  localparam logic [4:0] ST_K_SET  = 5'd10;
  localparam logic [4:0] ST_W_MUL  = 5'd11;
  localparam logic [4:0] ST_W_SET  = 5'd12;
  localparam logic [4:0] ST_N_MUL  = 5'd13;
  localparam logic [4:0] ST_N_SET  = 5'd14;
  localparam logic [4:0] ST_E_MUL  = 5'd15;
  localparam logic [4:0] ST_E_SET  = 5'd16;
  localparam logic [4:0] ST_I_MUL  = 5'd17;
  localparam logic [4:0] ST_I_SET  = 5'd18;
  localparam logic [4:0] ST_D_MUL  = 5'd19;
  localparam logic [4:0] ST_D_SET  = 5'd20;
  localparam logic [4:0] ST_ACC    = 5'd21;
  localparam logic [4:0] ST_LAST   = 5'd22;

  function automatic logic [64:0] sat_add(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    logic [64:0] r;
    s = {a[63], a} + {b[63], b};
    if (!s[64] && s[63]) r = {1'b1, SUM_POS_MAX};
    else if (s[64] && (!s[63] || s[62:0] == 63'd0)) r = {1'b1, SUM_NEG_MAX};
    else r = {1'b0, s[63:0]};
    return r;
  endfunction

  logic [31:0] exp_tab [TAB_N+1];
  for (genvar gi = 0; gi <= TAB_N; gi++) begin : g_tab
    assign exp_tab[gi] = exp_entry(gi, EXP_TABLE_BITS);
  end

  logic [4:0]  state_q, state_d;
  item_t       item_q;
  logic        dim_q;
  logic [71:0] p_q;
  logic [31:0] u_q;
  logic [30:0] om_q, t_q, c3_q;
  logic [34:0] a_q;
  logic [32:0] kmag_q [2];
  logic [1:0]  kneg_q;
  logic [35:0] wmag_q;
  logic        wneg_q;
  logic [63:0] nt_q, dt_q;
  logic [4:0]  n_q, sh_q;
  logic [31:0] lo_q, diff_q, b_q;
  logic [29:0] rem_q;
  logic [63:0] num_q, den_q;
  logic        ovf_q;

  logic        mul_en;
  logic [35:0] opa, opb;
  logic [29:0] v30;
  logic [34:0] a_n, a_abs;
  logic [31:0] y_bits, y_abs;
  logic [19:0] s_bits, s_abs;
  logic [63:0] nt_mag, nt_n;
  logic [50:0] pp;
  logic [IW-1:0] lo_idx, hi_idx;
  logic [31:0] m_n;
  logic [4:0]  n_abs;
  logic [71:0] d_shift;
  logic [63:0] dt_n;
  logic [64:0] num_sum, den_sum;

  assign v30     = p_q[63:34];
  assign a_n     = THREE_Q30 - (35'(v30) << 3) - (35'(v30) << 1) - 35'(v30);
  assign a_abs   = a_q[34] ? (35'd0 - a_q) : a_q;
  assign y_bits  = item_q.response;
  assign y_abs   = y_bits[31] ? (32'd0 - y_bits) : y_bits;
  assign s_bits  = item_q.score;
  assign s_abs   = s_bits[19] ? (20'd0 - s_bits) : s_bits;
  assign nt_mag  = 64'(p_q[67:16]);
  assign nt_n    = (wneg_q ^ y_bits[31]) ? (64'd0 - nt_mag) : nt_mag;
  assign pp      = s_bits[19] ? (51'd0 - p_q[50:0]) : p_q[50:0];
  assign lo_idx  = {1'b0, pp[45 -: EXP_TABLE_BITS]};
  assign hi_idx  = lo_idx + IW'(1);
  assign m_n     = lo_q + p_q[61:30];
  assign n_abs   = 5'd0 - n_q;
  assign d_shift = p_q >> sh_q;
  assign dt_n    = wneg_q ? (64'd0 - d_shift[63:0]) : d_shift[63:0];
  assign num_sum = sat_add(num_q, nt_q);
  assign den_sum = sat_add(den_q, dt_q);

  assign item_take_o   = (state_q == ST_IDLE) && item_valid_i;
  assign batch_valid_o = (state_q == ST_LAST) && item_q.last;
  assign batch_o.num   = num_q;
  assign batch_o.den   = den_q;
  assign batch_o.ovf   = ovf_q;

  always_comb begin
    mul_en = 1'b1;
    opa    = '0;
    opb    = '0;
    case (state_q)
      ST_U_MUL: begin
        opa = 36'(dim_q ? item_q.dist_landmark : item_q.dist_time);
        opb = 36'(dim_q ? cfg_i.inv_bw_landmark : cfg_i.inv_bw_time);
      end
      ST_V_MUL: begin
        opa = 36'(u_q);
        opb = 36'(u_q);
      end
      ST_O2_MUL: begin
        opa = 36'(om_q);
        opb = 36'(om_q);
      end
      ST_O3_MUL: begin
        opa = 36'(t_q);
        opb = 36'(om_q);
      end
      ST_K_MUL: begin
        opa = 36'(a_abs);
        opb = 36'(c3_q);
      end
      ST_W_MUL: begin
        opa = 36'(kmag_q[0]);
        opb = 36'(kmag_q[1]);
      end
      ST_N_MUL: begin
        opa = wmag_q;
        opb = 36'(y_abs);
      end
      ST_E_MUL: begin
        opa = 36'(s_abs);
        opb = 36'(LOG2E_Q30);
      end
      ST_I_MUL: begin
        opa = 36'(diff_q);
        opb = 36'(rem_q);
      end
      ST_D_MUL: begin
        opa = wmag_q;
        opb = 36'(b_q);
      end
      default: mul_en = 1'b0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (item_valid_i) state_d = item_i.hit ? ST_U_MUL : ST_LAST;
      end
      ST_U_MUL:  state_d = ST_U_CHK;
      ST_U_CHK:  state_d = (p_q[63:32] != 32'd0) ? ST_LAST : ST_V_MUL;
      ST_V_MUL:  state_d = ST_V_SET;
      ST_V_SET:  state_d = ST_O2_MUL;
      ST_O2_MUL: state_d = ST_O2_SET;
      ST_O2_SET: state_d = ST_O3_MUL;
      ST_O3_MUL: state_d = ST_O3_SET;
      ST_O3_SET: state_d = ST_K_MUL;
      ST_K_MUL:  state_d = ST_K_SET;
      ST_K_SET:  state_d = dim_q ? ST_W_MUL : ST_U_MUL;
      ST_W_MUL:  state_d = ST_W_SET;
      ST_W_SET:  state_d = ST_N_MUL;
      ST_N_MUL:  state_d = ST_N_SET;
      ST_N_SET:  state_d = ST_E_MUL;
      ST_E_MUL:  state_d = ST_E_SET;
      ST_E_SET:  state_d = ST_I_MUL;
      ST_I_MUL:  state_d = ST_I_SET;
      ST_I_SET:  state_d = ST_D_MUL;
      ST_D_MUL:  state_d = ST_D_SET;
      ST_D_SET:  state_d = ST_ACC;
      ST_ACC:    state_d = ST_LAST;
      ST_LAST: begin
        if (!item_q.last || batch_ready_i) state_d = ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) p_q <= opa * opb;
    case (state_q)
      ST_IDLE: begin
        item_q <= item_i;
        dim_q  <= 1'b0;
      end
      ST_U_CHK: u_q <= p_q[31:0];
      ST_V_SET: begin
        om_q <= ONE_Q30 - 31'(v30);
        a_q  <= a_n;
      end
      ST_O2_SET: t_q  <= p_q[60:30];
      ST_O3_SET: c3_q <= p_q[60:30];
      ST_K_SET: begin
        kmag_q[dim_q] <= p_q[62:30];
        kneg_q[dim_q] <= a_q[34];
        dim_q         <= 1'b1;
      end
      ST_W_SET: begin
        wmag_q <= p_q[65:30];
        wneg_q <= kneg_q[0] ^ kneg_q[1];
      end
      ST_N_SET: nt_q <= nt_n;
      ST_E_SET: begin
        n_q    <= pp[50:46];
        rem_q  <= pp[45-EXP_TABLE_BITS -: 30];
        lo_q   <= exp_tab[lo_idx];
        diff_q <= exp_tab[hi_idx] - exp_tab[lo_idx];
      end
      ST_I_SET: begin
        b_q  <= n_q[4] ? (m_n >> n_abs) : m_n;
        sh_q <= n_q[4] ? 5'd30 : (5'd30 - n_q);
      end
      ST_D_SET: dt_q <= dt_n;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      num_q   <= '0;
      den_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_ACC) begin
        num_q <= num_sum[63:0];
        den_q <= den_sum[63:0];
        if (num_sum[64] || den_sum[64]) ovf_q <= 1'b1;
      end else if (batch_valid_o && batch_ready_i) begin
        num_q <= '0;
        den_q <= '0;
        ovf_q <= 1'b0;
      end
    end
  end

endmodule

>>> src/kwre_div.sv
`timescale 1ns / 1ps
// kwre_div: bit-serial restoring division of the batch sums into a saturated Q16.16 ratio.
// Depends on kwre_pkg.
module kwre_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              batch_valid_i,
  input  kwre_pkg::batch_t  batch_i,
  output logic              batch_ready_o,
  output logic              res_valid_o,
  output kwre_pkg::result_t res_o,
  input  logic              res_ready_i
);
  import kwre_pkg::*;

  localparam int unsigned QBITS = 47;

  localparam logic [2:0] D_IDLE = 3'd0;
  localparam logic [2:0] D_CHK  = 3'd1;
  localparam logic [2:0] D_RUN  = 3'd2;
  localparam logic [2:0] D_FIX  = 3'd3;
  localparam logic [2:0] D_DONE = 3'd4;

  logic [2:0]       state_q;
  logic [63:0]      nm_q, dm_q, rem_q;
  logic [QBITS-1:0] sreg_q, q_q;
  logic [5:0]       cnt_q;
  logic             neg_q, zero_q, ovf_q;
  result_t          res_q;

  logic [63:0]      trial;
  logic             qbit;
  logic [QBITS-1:0] lim, q_clip;

  assign batch_ready_o = (state_q == D_IDLE);
  assign res_valid_o   = (state_q == D_DONE);
  assign res_o         = res_q;
  assign trial         = {rem_q[62:0], sreg_q[QBITS-1]};
  assign qbit          = (trial >= dm_q);
  assign lim           = neg_q ? QBITS'(33'h0_8000_0000) : QBITS'(33'h0_7FFF_FFFF);
  assign q_clip        = (q_q > lim) ? lim : q_q;

  always_ff @(posedge clk_i) begin
    case (state_q)
      D_IDLE: begin
        nm_q   <= batch_i.num[63] ? (64'd0 - batch_i.num) : batch_i.num;
        dm_q   <= batch_i.den[63] ? (64'd0 - batch_i.den) : batch_i.den;
        neg_q  <= batch_i.num[63] ^ batch_i.den[63];
        zero_q <= (batch_i.den == 64'd0);
        ovf_q  <= batch_i.ovf;
      end
      D_CHK: begin
        rem_q  <= 64'(nm_q[62:31]);
        sreg_q <= {nm_q[30:0], 16'd0};
        q_q    <= '0;
        res_q.saturated    <= ovf_q;
        res_q.empty_window <= zero_q;
        if (zero_q) begin
          res_q.estimate <= '0;
        end else if ({31'd0, nm_q} >= {dm_q, 31'd0}) begin
          res_q.estimate  <= neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
          res_q.saturated <= 1'b1;
        end
      end
      D_RUN: begin
        rem_q  <= qbit ? (trial - dm_q) : trial;
        q_q    <= {q_q[QBITS-2:0], qbit};
        sreg_q <= sreg_q << 1;
      end
      D_FIX: begin
        res_q.estimate <= neg_q ? (32'd0 - q_clip[31:0]) : q_clip[31:0];
        if (q_q > lim) res_q.saturated <= 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        D_IDLE: begin
          if (batch_valid_i) state_q <= D_CHK;
        end
        D_CHK: begin
          cnt_q <= '0;
          if (zero_q || ({31'd0, nm_q} >= {dm_q, 31'd0})) state_q <= D_DONE;
          else state_q <= D_RUN;
        end
        D_RUN: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'(QBITS - 1)) state_q <= D_FIX;
        end
        D_FIX: state_q <= D_DONE;
        D_DONE: begin
          if (res_ready_i) state_q <= D_IDLE;
        end
        default: state_q <= D_IDLE;
      endcase
    end
  end

endmodule

>>> bench/kwre_checker.sv
`timescale 1ns / 1ps
// kwre_checker: watches the configuration, subject and estimate channels of the ratio
// estimator, predicts each batch estimate and compares it field by field. Uses kwre_pkg.
module kwre_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               push_i,
  input  logic               full_i,
  input  logic signed [31:0] subject_time_i,
  input  logic signed [31:0] subject_landmark_i,
  input  logic signed [31:0] response_i,
  input  logic [1:0]         group_i,
  input  logic signed [19:0] linear_score_i,
  input  logic               last_subject_i,
  input  logic               empty_i,
  input  logic               pop_i,
  input  logic signed [31:0] estimate_i,
  input  logic               empty_window_i,
  input  logic               saturated_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o
);
  import kwre_pkg::*;

  localparam int unsigned TABLE_BITS = 4;
  localparam logic [63:0] Q30_ONE = 64'd1 << 30;
  localparam logic [63:0] MAG_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

  logic [63:0] pow2_frac [0:(1 << TABLE_BITS)];
  cfg_t        regs;
  logic signed [63:0] num_acc;
  logic signed [63:0] den_acc;
  logic        sticky_ovf;
  result_t     estimates_due [$];
  int unsigned fails;

  assign fail_count_o = fails;
  assign pending_o    = estimates_due.size();

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  initial begin
    logic [63:0] step;
    step = 64'd2 << 30;
    for (int i = 0; i < TABLE_BITS; i++) step = int_sqrt(step << 30);
    pow2_frac[0] = Q30_ONE;
    for (int i = 1; i < (1 << TABLE_BITS); i++)
      pow2_frac[i] = (pow2_frac[i-1] * step + (Q30_ONE >> 1)) >> 30;
    pow2_frac[1 << TABLE_BITS] = 64'd2 << 30;
  end

  function automatic logic [63:0] magnitude(logic signed [63:0] a);
    return (a < 0) ? -a : a;
  endfunction

  function automatic logic signed [63:0] scaled_product(logic signed [63:0] a,
      logic signed [63:0] b, int unsigned sh, inout logic ovf);
    logic [127:0] p;
    logic [63:0]  m;
    p = ({64'd0, magnitude(a)} * {64'd0, magnitude(b)}) >> sh;
    if (p > {64'd0, MAG_LIMIT}) begin
      ovf = 1'b1;
      m   = MAG_LIMIT;
    end else begin
      m = p[63:0];
    end
    return ((a < 0) != (b < 0)) ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [63:0] clamped_sum(logic signed [63:0] a,
      logic signed [63:0] b, inout logic ovf);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s > $signed({1'b0, MAG_LIMIT})) begin
      ovf = 1'b1;
      return MAG_LIMIT;
    end
    if (s < -$signed({1'b0, MAG_LIMIT})) begin
      ovf = 1'b1;
      return -$signed(MAG_LIMIT);
    end
    return s[63:0];
  endfunction

  function automatic logic window_weight(logic signed [31:0] ev, logic signed [31:0] subj,
      logic [31:0] inv_bw, output logic signed [63:0] k);
    logic signed [63:0] d;
    logic signed [63:0] a;
    logic [63:0] u;
    logic [63:0] v30;
    logic [63:0] om;
    logic [63:0] c3;
    logic        dummy;
    dummy = 1'b0;
    k = '0;
    d = {{32{ev[31]}}, ev} - {{32{subj[31]}}, subj};
    u = magnitude(d) * {32'd0, inv_bw};
    if (u >= (64'd1 << 32)) return 1'b0;
    v30 = (u * u) >> 34;
    om  = Q30_ONE - v30;
    c3  = (((om * om) >> 30) * om) >> 30;
    a   = $signed(64'd3 * Q30_ONE) - $signed(64'd11 * v30);
    k   = scaled_product(a, $signed(c3), 30, dummy);
    return 1'b1;
  endfunction

  function automatic logic [63:0] exp_of_score(logic signed [19:0] s);
    logic signed [63:0] p;
    logic signed [63:0] n;
    logic [45:0] f;
    logic [63:0] idx;
    logic [63:0] rem;
    logic [63:0] m;
    p   = {{44{s[19]}}, s} * $signed({33'd0, LOG2E_Q30});
    n   = p >>> 46;
    f   = p[45:0];
    idx = f >> (46 - TABLE_BITS);
    rem = (f & ((46'd1 << (46 - TABLE_BITS)) - 1)) >> (16 - TABLE_BITS);
    m   = pow2_frac[idx] + (((pow2_frac[idx+1] - pow2_frac[idx]) * rem) >> 30);
    return (n >= 0) ? (m << n) : (m >> (-n));
  endfunction

  function automatic result_t batch_estimate(logic signed [63:0] nsum,
      logic signed [63:0] dsum, logic ovf);
    result_t      r;
    logic [127:0] q;
    logic [63:0]  lim;
    logic         neg;
    r.estimate     = '0;
    r.empty_window = (dsum == 0);
    r.saturated    = ovf;
    if (dsum != 0) begin
      neg = (nsum < 0) != (dsum < 0);
      lim = neg ? (64'd1 << 31) : ((64'd1 << 31) - 1);
      q   = {64'd0, magnitude(nsum)} / {64'd0, magnitude(dsum)};
      if (q >= (128'd1 << 31)) begin
        q = lim;
        r.saturated = 1'b1;
      end else begin
        q = ({64'd0, magnitude(nsum)} << 16) / {64'd0, magnitude(dsum)};
        if (q > lim) begin
          q = lim;
          r.saturated = 1'b1;
        end
      end
      r.estimate = neg ? -q[31:0] : q[31:0];
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [63:0] kt;
    logic signed [63:0] kl;
    logic signed [63:0] w;
    logic signed [63:0] nterm;
    logic signed [63:0] dterm;
    logic               ovf;
    result_t            want;
    if (!rst_ni) begin
      regs.eval_time       <= '0;
      regs.eval_landmark   <= '0;
      regs.inv_bw_time     <= 32'd65536;
      regs.inv_bw_landmark <= 32'd65536;
      regs.target_group    <= 2'd1;
      num_acc    <= '0;
      den_acc    <= '0;
      sticky_ovf <= 1'b0;
      fails      <= 0;
      estimates_due.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_EVAL_TIME:       regs.eval_time       <= cfg_data_i;
          CFG_EVAL_LANDMARK:   regs.eval_landmark   <= cfg_data_i;
          CFG_INV_BW_TIME:     regs.inv_bw_time     <= cfg_data_i;
          CFG_INV_BW_LANDMARK: regs.inv_bw_landmark <= cfg_data_i;
          CFG_TARGET_GROUP:    regs.target_group    <= cfg_data_i[1:0];
          default: ;
        endcase
      end
      if (pop_i && !empty_i) begin
        if (estimates_due.size() == 0) begin
          fails <= fails + 1;
          if (fails < 10) $display("unexpected estimate %0d at %0t", estimate_i, $realtime);
        end else begin
          want = estimates_due.pop_front();
          if (estimate_i !== want.estimate || empty_window_i !== want.empty_window ||
              saturated_i !== want.saturated) begin
            fails <= fails + 1;
            if (fails < 10)
              $display("estimate mismatch: expected %0d/%b/%b got %0d/%b/%b",
                       want.estimate, want.empty_window, want.saturated,
                       estimate_i, empty_window_i, saturated_i);
          end
        end
      end
      if (push_i && !full_i) begin
        logic signed [63:0] nacc;
        logic signed [63:0] dacc;
        nacc = num_acc;
        dacc = den_acc;
        ovf  = sticky_ovf;
        if (group_i == regs.target_group &&
            window_weight(regs.eval_time, subject_time_i, regs.inv_bw_time, kt) &&
            window_weight(regs.eval_landmark, subject_landmark_i, regs.inv_bw_landmark, kl))
        begin
          w     = scaled_product(kt, kl, 30, ovf);
          nterm = scaled_product(w, {{32{response_i[31]}}, response_i}, 16, ovf);
          dterm = scaled_product(w, $signed(exp_of_score(linear_score_i)), 30, ovf);
          nacc  = clamped_sum(nacc, nterm, ovf);
          dacc  = clamped_sum(dacc, dterm, ovf);
        end
        if (last_subject_i) begin
          estimates_due.push_back(batch_estimate(nacc, dacc, ovf));
          num_acc    <= '0;
          den_acc    <= '0;
          sticky_ovf <= 1'b0;
        end else begin
          num_acc    <= nacc;
          den_acc    <= dacc;
          sticky_ovf <= ovf;
        end
      end
    end
  end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// testbench: drives configuration phases and subject batches into the ratio estimator,
// pops estimates with random stalls and reports the verdict. Uses kwre_pkg and kwre_checker.
module testbench;
  import kwre_pkg::*;

  localparam int unsigned STALL_LIMIT = 20000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;
  logic               push = 1'b0;
  logic               full;
  logic signed [31:0] subj_time = '0;
  logic signed [31:0] subj_landmark = '0;
  logic signed [31:0] response = '0;
  logic [1:0]         group = '0;
  logic signed [19:0] score = '0;
  logic               last_subj = 1'b0;
  logic               empty;
  logic               pop = 1'b0;
  logic signed [31:0] estimate;
  logic               empty_window;
  logic               saturated;
  int unsigned        fail_count;
  int unsigned        pending;
  int unsigned        quiet_cycles = 0;
  logic               steady = 1'b0;
  logic [31:0]        cur [0:4];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  kernel_weighted_ratio_estimate DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .push(push), .full(full),
    .subject_time_i(subj_time), .subject_landmark_i(subj_landmark),
    .response_i(response), .group_i(group), .linear_score_i(score),
    .last_subject_i(last_subj),
    .empty(empty), .pop(pop),
    .estimate_o(estimate), .empty_window_o(empty_window), .saturated_o(saturated)
  );

  kwre_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .push_i(push), .full_i(full),
    .subject_time_i(subj_time), .subject_landmark_i(subj_landmark),
    .response_i(response), .group_i(group), .linear_score_i(score),
    .last_subject_i(last_subj),
    .empty_i(empty), .pop_i(pop),
    .estimate_i(estimate), .empty_window_i(empty_window), .saturated_i(saturated),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk) begin
    if (rst_n) pop <= steady || ($urandom_range(0, 99) >= 21);
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic drain_and_hold();
    if (push) push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic program_regs(logic [31:0] et, logic [31:0] el, logic [31:0] bt,
                              logic [31:0] bl, logic [1:0] tg);
    cur[0] = et; cur[1] = el; cur[2] = bt; cur[3] = bl; cur[4] = {30'd0, tg};
    cfg_valid <= 1'b1;
    for (int i = 0; i < 5; i++) begin
      case (i)
        0: cfg_index <= CFG_EVAL_TIME;
        1: cfg_index <= CFG_EVAL_LANDMARK;
        2: cfg_index <= CFG_INV_BW_TIME;
        3: cfg_index <= CFG_INV_BW_LANDMARK;
        default: cfg_index <= CFG_TARGET_GROUP;
      endcase
      cfg_data <= cur[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_subject(logic [31:0] t, logic [31:0] l, logic [31:0] y,
                              logic [1:0] g, logic [19:0] s, logic last);
    push          <= 1'b1;
    subj_time     <= t;
    subj_landmark <= l;
    response      <= y;
    group         <= g;
    score         <= s;
    last_subj     <= last;
    do @(posedge clk); while (full);
    if (!steady && $urandom_range(0, 99) < 21) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] near_point(logic [31:0] centre, logic [31:0] inv_bw);
    logic [63:0] reach;
    logic [31:0] off;
    reach = (inv_bw == 0) ? 64'h7FFF_FFFF : (64'hFFFF_FFFF / inv_bw);
    if (reach > 64'h7FFF_FFFF) reach = 64'h7FFF_FFFF;
    off = $urandom_range(0, reach[31:0]);
    if ($urandom_range(0, 3) == 0) off = reach[31:0] - $urandom_range(0, 3);
    return $urandom_range(0, 1) ? centre + off : centre - off;
  endfunction

  task automatic random_subject(logic last);
    logic [31:0] t;
    logic [31:0] l;
    logic [1:0]  g;
    if ($urandom_range(0, 99) < 85) begin
      t = near_point(cur[0], cur[2]);
      l = near_point(cur[1], cur[3]);
      g = ($urandom_range(0, 99) < 85) ? cur[4][1:0] : 2'($urandom);
    end else begin
      t = $urandom;
      l = $urandom;
      g = 2'($urandom);
    end
    send_subject(t, l, $urandom, g, 20'($urandom), last);
  endtask

  function automatic logic [31:0] random_bw();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return 32'd1 << $urandom_range(8, 22);
    endcase
  endfunction

  initial begin
    int unsigned sent;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults straight out of reset
    cur[0] = 0; cur[1] = 0; cur[2] = 32'd65536; cur[3] = 32'd65536; cur[4] = 1;
    send_subject(0, 0, 32'h7FFF_FFFF, 2'd1, 20'h7FFFF, 1'b1);
    send_subject(0, 0, 32'h8000_0000, 2'd1, 20'h80000, 1'b1);
    send_subject(32'h0000_8000, 32'hFFFF_8000, 32'h0001_0000, 2'd1, 20'd0, 1'b0);
    send_subject(32'h0000_F000, 32'h0000_F000, 32'hFFFF_0000, 2'd1, 20'h10000, 1'b1);
    send_subject(0, 0, 32'h0001_0000, 2'd2, 20'd0, 1'b1);
    send_subject(32'h0001_0000, 0, 32'h0001_0000, 2'd1, 20'd0, 1'b1);
    send_subject(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 2'd1, 20'd0, 1'b1);
    drain_and_hold();

    // zero reciprocal bandwidth: every subject inside; tiny denominator saturates
    program_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'd0, 2'd3);
    send_subject(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 2'd3, 20'h80000, 1'b1);
    send_subject(0, 0, 32'h8000_0000, 2'd3, 20'h80000, 1'b0);
    send_subject(32'h1234_5678, 32'h8765_4321, 32'h8000_0000, 2'd3, 20'h80000, 1'b1);
    send_subject(0, 0, 32'h0003_0000, 2'd3, 20'h7FFFF, 1'b1);
    drain_and_hold();

    // widest reciprocal: only points within one unit of the centre lie inside
    program_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd0);
    send_subject(32'h8000_0000, 32'h7FFF_FFFF, 32'h0002_0000, 2'd0, 20'd0, 1'b1);
    send_subject(32'h8000_0001, 32'h7FFF_FFFF, 32'h0002_0000, 2'd0, 20'd0, 1'b1);
    send_subject(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFE_0000, 2'd0, 20'hF0000, 1'b1);
    drain_and_hold();

    sent = 0;
    while (sent < 400) begin
      program_regs($urandom, $urandom, random_bw(), random_bw(), 2'($urandom));
      steady = (sent >= 160 && sent < 240);
      repeat ($urandom_range(4, 10)) begin
        int unsigned batch;
        batch = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 6);
        for (int i = 1; i <= batch; i++) random_subject(i == batch);
        sent += batch;
      end
      drain_and_hold();
    end
    steady = 1'b0;

    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
